>>> sv/hbk_pkg.sv
package hbk_pkg;

  // Report geometry
  localparam int KEY_SLOTS = 6;
  localparam int MOD_BITS  = 8;
  localparam int EV_NUM    = MOD_BITS + 2 * KEY_SLOTS;

  typedef logic [7:0] usage_t;
  typedef logic [6:0] ascii_t;

  // Usage codes
  localparam usage_t EMPTY_LAST     = 8'h03;
  localparam usage_t MOD_USAGE_BASE = 8'hE0;
  localparam usage_t SHIFT_MASK     = 8'h22;

  // What one slot lane found
  typedef struct packed {
    logic   rel_hit;
    logic   prs_hit;
    ascii_t ascii;
  } lane_res_t;

  // US layout character of a usage id, 0 where the key has none
  function automatic ascii_t char_of(usage_t key, logic shift);
    ascii_t ch;
    ascii_t off;
    off = key[6:0] - 7'h04;
    case (key) inside
      [8'h04:8'h1D]: ch = shift ? (off + 7'h41) : (off + 7'h61);
      8'h1E:         ch = shift ? 7'h21 : 7'h31;
      8'h1F:         ch = shift ? 7'h40 : 7'h32;
      8'h20:         ch = shift ? 7'h23 : 7'h33;
      8'h21:         ch = shift ? 7'h24 : 7'h34;
      8'h22:         ch = shift ? 7'h25 : 7'h35;
      8'h23:         ch = shift ? 7'h5E : 7'h36;
      8'h24:         ch = shift ? 7'h26 : 7'h37;
      8'h25:         ch = shift ? 7'h2A : 7'h38;
      8'h26:         ch = shift ? 7'h28 : 7'h39;
      8'h27:         ch = shift ? 7'h29 : 7'h30;
      8'h2C:         ch = 7'h20;
      8'h2D:         ch = shift ? 7'h5F : 7'h2D;
      8'h2E:         ch = shift ? 7'h2B : 7'h3D;
      8'h2F:         ch = shift ? 7'h7B : 7'h5B;
      8'h30:         ch = shift ? 7'h7D : 7'h5D;
      8'h31:         ch = shift ? 7'h7C : 7'h5C;
      8'h33:         ch = shift ? 7'h3A : 7'h3B;
      8'h34:         ch = shift ? 7'h22 : 7'h27;
      8'h35:         ch = shift ? 7'h7E : 7'h60;
      8'h36:         ch = shift ? 7'h3C : 7'h2C;
      8'h37:         ch = shift ? 7'h3E : 7'h2E;
      8'h38:         ch = shift ? 7'h3F : 7'h2F;
      default:       ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/hid_boot_keyboard_event_diff_core.sv
// Boot keyboard report differ.
// Input channel: in_valid_i / in_stall_o with one boot report per request
// (report_valid_i, modifier_bits_i, key_slot_0_i .. key_slot_5_i). A request
// with report_valid_i low is consumed and produces nothing.
// Output channel: out_valid_o / out_stall_i, one key event per request:
// modifier edges first (bit 0 to 7), then per slot a release of the old
// key and a press of the new key. last_event_o marks a report's final event.
// Six slot lanes compare the report against the stored one in the accept
// cycle; a serializer then sends one event per cycle, while the receiver does
// not stall, from the output register. An accepted report is first held as a
// pending event mask, from which its events are loaded into the output
// register. A report has at most 20 events, all sent by the single event
// serializer. The next report is accepted in the cycle the current report's
// last event moves out. Reset clears the stored report to zero and drops all
// pending events. While the receiver stalls, the output holds, and in_stall_o
// stays high as long as events of the current report are still pending.
module hid_boot_keyboard_event_diff_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            report_valid_i,
  input  logic [7:0]      modifier_bits_i,
  input  logic [7:0]      key_slot_0_i,
  input  logic [7:0]      key_slot_1_i,
  input  logic [7:0]      key_slot_2_i,
  input  logic [7:0]      key_slot_3_i,
  input  logic [7:0]      key_slot_4_i,
  input  logic [7:0]      key_slot_5_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            is_modifier_o,
  output logic [7:0]      usage_code_o,
  output logic            pressed_o,
  output logic [6:0]      ascii_code_o,
  output logic [7:0]      modifier_now_o,
  output logic            last_event_o
);
  import hbk_pkg::*;

  usage_t                    prev_mods_q;
  usage_t [KEY_SLOTS-1:0]    prev_keys_q;
  usage_t [KEY_SLOTS-1:0]    new_keys;
  lane_res_t [KEY_SLOTS-1:0] lane_res;
  logic [EV_NUM-1:0]         ev_mask;
  logic                      shift;
  logic                      accept;
  logic                      load;

  assign new_keys[0] = key_slot_0_i;
  assign new_keys[1] = key_slot_1_i;
  assign new_keys[2] = key_slot_2_i;
  assign new_keys[3] = key_slot_3_i;
  assign new_keys[4] = key_slot_4_i;
  assign new_keys[5] = key_slot_5_i;

  assign shift  = (modifier_bits_i & SHIFT_MASK) != '0;
  assign accept = in_valid_i && !in_stall_o;
  assign load   = accept && report_valid_i;

  // Compare each slot in its own lane
  for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_lane
    hbk_lane u_lane (
      .old_key_i  (prev_keys_q[s]),
      .new_key_i  (new_keys[s]),
      .old_keys_i (prev_keys_q),
      .new_keys_i (new_keys),
      .shift_i    (shift),
      .res_o      (lane_res[s])
    );
  end

  // Collect modifier edges and lane hits into one event mask
  always_comb begin
    ev_mask[MOD_BITS-1:0] = modifier_bits_i ^ prev_mods_q;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      ev_mask[MOD_BITS + 2 * s]     = lane_res[s].rel_hit;
      ev_mask[MOD_BITS + 2 * s + 1] = lane_res[s].prs_hit;
    end
  end

  // Store the accepted report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else if (load) begin
      prev_mods_q <= modifier_bits_i;
      prev_keys_q <= new_keys;
    end
  end

  hbk_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .mask_i         (ev_mask),
    .mods_i         (modifier_bits_i),
    .old_keys_i     (prev_keys_q),
    .new_keys_i     (new_keys),
    .lanes_i        (lane_res),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_modifier_o  (is_modifier_o),
    .usage_code_o   (usage_code_o),
    .pressed_o      (pressed_o),
    .ascii_code_o   (ascii_code_o),
    .modifier_now_o (modifier_now_o),
    .last_event_o   (last_event_o)
  );

endmodule

>>> sv/hbk_lane.sv
module hbk_lane (
  input  hbk_pkg::usage_t                          old_key_i,
  input  hbk_pkg::usage_t                          new_key_i,
  input  hbk_pkg::usage_t [hbk_pkg::KEY_SLOTS-1:0] old_keys_i,
  input  hbk_pkg::usage_t [hbk_pkg::KEY_SLOTS-1:0] new_keys_i,
  input  logic                                     shift_i,
  output hbk_pkg::lane_res_t                       res_o
);
  import hbk_pkg::*;

  logic old_in_new;
  logic new_in_old;

  // Look up this slot's old key in the new set and its new key in the old set
  always_comb begin
    old_in_new = 1'b0;
    new_in_old = 1'b0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (new_keys_i[s] == old_key_i) old_in_new = 1'b1;
      if (old_keys_i[s] == new_key_i) new_in_old = 1'b1;
    end
  end

  // Flag release and press, look up the character
  always_comb begin
    res_o.rel_hit = (old_key_i > EMPTY_LAST) && !old_in_new;
    res_o.prs_hit = (new_key_i > EMPTY_LAST) && !new_in_old;
    res_o.ascii   = char_of(new_key_i, shift_i);
  end

endmodule

>>> sv/hbk_merge.sv
module hbk_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  logic [hbk_pkg::EV_NUM-1:0]                mask_i,
  input  hbk_pkg::usage_t                           mods_i,
  input  hbk_pkg::usage_t [hbk_pkg::KEY_SLOTS-1:0]  old_keys_i,
  input  hbk_pkg::usage_t [hbk_pkg::KEY_SLOTS-1:0]  new_keys_i,
  input  hbk_pkg::lane_res_t [hbk_pkg::KEY_SLOTS-1:0] lanes_i,
  output logic                                      in_stall_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      is_modifier_o,
  output hbk_pkg::usage_t                           usage_code_o,
  output logic                                      pressed_o,
  output hbk_pkg::ascii_t                           ascii_code_o,
  output hbk_pkg::usage_t                           modifier_now_o,
  output logic                                      last_event_o
);
  import hbk_pkg::*;

  // Pending request: events still to send and the data they draw from
  logic [EV_NUM-1:0]            mask_q, mask_d;
  usage_t                       mods_q;
  usage_t [KEY_SLOTS-1:0]       old_q;
  usage_t [KEY_SLOTS-1:0]       new_q;
  ascii_t [KEY_SLOTS-1:0]       ascii_q;

  // Output register
  logic   out_valid_q, out_valid_d;
  logic   is_mod_q;
  usage_t usage_q;
  logic   pressed_q;
  ascii_t ascii_out_q;
  usage_t mods_out_q;
  logic   last_q;

  logic [EV_NUM-1:0] pick_oh;
  logic              busy;
  logic              last;
  logic              out_load;
  logic              adv;
  logic              ev_is_mod;
  usage_t            ev_usage;
  logic              ev_pressed;
  ascii_t            ev_ascii;

  // Pick the lowest pending event
  assign pick_oh  = mask_q & (~mask_q + EV_NUM'(1));
  assign busy     = |mask_q;
  assign last     = ((mask_q & ~pick_oh) == '0);
  assign out_load = !out_valid_q || !out_stall_i;
  assign adv      = busy && out_load;

  // Take a new request once the last event of the current one moves out
  assign in_stall_o = busy && !(out_load && last);

  // Form the picked event
  always_comb begin
    ev_is_mod  = 1'b0;
    ev_usage   = '0;
    ev_pressed = 1'b0;
    ev_ascii   = '0;
    for (int b = 0; b < MOD_BITS; b++) begin
      if (pick_oh[b]) begin
        ev_is_mod  = 1'b1;
        ev_usage   = MOD_USAGE_BASE + usage_t'(b);
        ev_pressed = mods_q[b];
      end
    end
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (pick_oh[MOD_BITS + 2 * s]) begin
        ev_usage = old_q[s];
      end
      if (pick_oh[MOD_BITS + 2 * s + 1]) begin
        ev_usage   = new_q[s];
        ev_pressed = 1'b1;
        ev_ascii   = ascii_q[s];
      end
    end
  end

  // Load a new request or drop the sent event
  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = mask_i;
    end else if (adv) begin
      mask_d = mask_q & ~pick_oh;
    end
  end

  // Advance the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold request data
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mods_q <= mods_i;
      old_q  <= old_keys_i;
      new_q  <= new_keys_i;
      for (int s = 0; s < KEY_SLOTS; s++) begin
        ascii_q[s] <= lanes_i[s].ascii;
      end
    end
  end

  // Hold event payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      is_mod_q    <= ev_is_mod;
      usage_q     <= ev_usage;
      pressed_q   <= ev_pressed;
      ascii_out_q <= ev_ascii;
      mods_out_q  <= mods_q;
      last_q      <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_modifier_o  = is_mod_q;
  assign usage_code_o   = usage_q;
  assign pressed_o      = pressed_q;
  assign ascii_code_o   = ascii_out_q;
  assign modifier_now_o = mods_out_q;
  assign last_event_o   = last_q;

  // A request with events shows as busy next cycle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (mask_i != '0)) |=> busy)
    else $error("pending request lost after load");

  // Without a load, no event bit is ever added
  a_mask_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_i |=> ((mask_q & ~$past(mask_q)) == '0))
    else $error("event bit appeared without a load");

  // A sent event is cleared
  a_sent_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !load_i) |=> ((mask_q & $past(pick_oh)) == '0))
    else $error("sent event still pending");

  // The final event of a request carries the last mark
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last && !load_i) |=> (!busy && out_valid_q && last_q))
    else $error("final event not marked or request not retired");

endmodule
